[src/akf_pkg.sv]
// ============================================================================
// akf_pkg: shared types and constants for the angle Kalman filter
// Register indexes, reset values, sequencer states and the divider response.
// ============================================================================
`default_nettype none

package akf_pkg;

    // Configuration port
    localparam int CfgIdxW = 8;
    localparam int CfgDataW = 31;

    localparam logic [CfgIdxW-1:0] CfgAngleNoise = CfgIdxW'(0);
    localparam logic [CfgIdxW-1:0] CfgBiasNoise  = CfgIdxW'(1);
    localparam logic [CfgIdxW-1:0] CfgMeasNoise  = CfgIdxW'(2);
    localparam logic [CfgIdxW-1:0] CfgPeriod     = CfgIdxW'(3);

    // Register reset values, unsigned Q1.30
    localparam logic [CfgDataW-1:0] AngleNoiseRst = 31'd1073742;
    localparam logic [CfgDataW-1:0] BiasNoiseRst  = 31'd3221225;
    localparam logic [CfgDataW-1:0] MeasNoiseRst  = 31'd536870912;
    localparam logic [CfgDataW-1:0] PeriodRst     = 31'd5368709;

    // Covariance diagonal after reset: 1.0 in Q2.30
    localparam logic signed [31:0] OneQ30 = 32'sd1073741824;

    // Divider: one quotient bit per cycle
    localparam int DivSteps = 32;
    localparam int DivCntW  = $clog2(DivSteps);

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_CHECK,
        ST_DIV,
        ST_RESULT
    } t_state;

    // Multiply-accumulate steps, in execution order
    typedef enum logic [3:0] {
        OP_ANG_P,
        OP_P00_P,
        OP_P01_P,
        OP_P10_P,
        OP_P11_P,
        OP_P00_C,
        OP_P01_C,
        OP_P10_C,
        OP_P11_C,
        OP_ANG_C,
        OP_BIAS_C
    } t_op;

    // Divider status back to the sequencer
    typedef struct packed {
        logic        done;
        logic [31:0] quot;
    } t_div_rsp;

    // Clamp a 36-bit signed value to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] res;
        if (v[35:31] == 5'b00000 || v[35:31] == 5'b11111) begin
            res = v[31:0];
        end else if (v[35]) begin
            res = 32'sh8000_0000;
        end else begin
            res = 32'sh7FFF_FFFF;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[src/akf_div.sv]
// ============================================================================
// akf_div: restoring divider for the Kalman gains
// Computes round((num << 30) / den) one quotient bit per cycle, clipped at 2^31.
// ============================================================================
`default_nettype none

module akf_div (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [31:0]      i_num,
    input  wire logic [31:0]      i_den,
    output akf_pkg::t_div_rsp     o_rsp
);

    localparam logic [31:0] QuotClip = 32'h8000_0000;

    logic                         r_busy;
    logic                         r_done;
    logic [akf_pkg::DivCntW-1:0]  r_cnt;
    logic [31:0]                  r_rem;
    logic [31:0]                  r_lo;
    logic [31:0]                  r_den;
    logic                         r_ovf;

    logic [61:0]                  w_dividend;
    logic                         w_ovf;
    logic [32:0]                  w_trial;
    logic [32:0]                  w_diff;
    logic                         w_ge;
    logic [31:0]                  n_rem;
    logic [31:0]                  n_lo;

    // Dividend with half the divisor added for round-to-nearest
    assign w_dividend = {i_num, 30'b0} + 62'(i_den[31:1]);
    assign w_ovf      = {2'b00, w_dividend[61:32]} >= i_den;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign w_trial = {r_rem, r_lo[31]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign n_rem   = w_ge ? w_diff[31:0] : w_trial[31:0];
    assign n_lo    = {r_lo[30:0], w_ge};

    // Step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == akf_pkg::DivCntW'(akf_pkg::DivSteps - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Partial remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {2'b00, w_dividend[61:32]};
            r_lo  <= w_dividend[31:0];
            r_den <= i_den;
            r_ovf <= w_ovf;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_lo  <= n_lo;
        end
    end

    // Clip the quotient at 2^31
    assign o_rsp.done = r_done;
    assign o_rsp.quot = (r_ovf || r_lo > QuotClip) ? QuotClip : r_lo;

endmodule

`default_nettype wire

[src/angle_kalman_filter_core.sv]
// ============================================================================
// angle_kalman_filter_core: two-state accelerometer/gyro angle Kalman filter
// Fuses an accelerometer angle and a gyro rate into a filtered angle and a
// bias-corrected rate, using one shared multiplier and a serial divider.
// ============================================================================
// Usage:
//   Input channel (i_in_valid/o_in_ready) takes one word: accel angle and
//   gyro rate, signed Q12.20. Output channel (o_out_valid/i_out_ready) gives
//   one word per input: filtered angle and bias-corrected rate, Q12.20.
//   Config channel (i_cfg_valid/o_cfg_ready) writes the noise terms and the
//   sample period by index; write only while the filter is idle.
//   The two gain divisions, one quotient bit per cycle, dominate the time
//   per word when the correction runs; the correction is skipped when the
//   innovation variance is not positive. Each of the eleven
//   multiply-accumulate steps passes a multiply state and an accumulate
//   state on the single 33x32 multiplier.
//   Reset (synchronous) loads the default registers, clears angle and bias
//   and sets the covariance to identity.
//   A stalled receiver holds the result in the output register; the next
//   word is still accepted and processed, and the filter waits only to hand
//   over its own result.
// ============================================================================
`default_nettype none

module angle_kalman_filter_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [akf_pkg::CfgIdxW-1:0]     i_cfg_index,
    input  wire logic [akf_pkg::CfgDataW-1:0]    i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic signed [31:0]              i_accel_angle,
    input  wire logic signed [31:0]              i_gyro_rate,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic signed [31:0]                   o_angle_estimate,
    output logic signed [31:0]                   o_rate_estimate
);

    // Configuration registers
    logic [akf_pkg::CfgDataW-1:0] r_angle_noise;
    logic [akf_pkg::CfgDataW-1:0] r_bias_noise;
    logic [akf_pkg::CfgDataW-1:0] r_meas_noise;
    logic [akf_pkg::CfgDataW-1:0] r_period;

    // Filter state
    logic signed [31:0] r_angle, n_angle;
    logic signed [31:0] r_bias, n_bias;
    logic signed [31:0] r_p00, n_p00;
    logic signed [31:0] r_p01, n_p01;
    logic signed [31:0] r_p10, n_p10;
    logic signed [31:0] r_p11, n_p11;

    // Sequencer
    akf_pkg::t_state r_state, n_state;
    akf_pkg::t_op    r_op, n_op;
    logic            r_ksel, n_ksel;
    logic            r_out_valid, n_out_valid;

    // Working registers
    logic signed [31:0] r_accel, n_accel;
    logic signed [31:0] r_gyro, n_gyro;
    logic signed [31:0] r_d0, n_d0;
    logic signed [31:0] r_k0, n_k0;
    logic signed [31:0] r_k1, n_k1;
    logic signed [31:0] r_err, n_err;
    logic signed [31:0] r_t0, n_t0;
    logic signed [31:0] r_t1, n_t1;
    logic [63:0]        r_prod, n_prod;
    logic               r_neg, n_neg;
    logic signed [31:0] r_angle_out, n_angle_out;
    logic signed [31:0] r_rate_out, n_rate_out;

    // Datapath signals
    logic signed [33:0] w_d0_sum;
    logic signed [32:0] w_e;
    logic               w_e_pos;
    logic signed [32:0] w_opa;
    logic signed [32:0] w_opb;
    logic               w_sub;
    logic signed [31:0] w_base;
    logic [32:0]        w_mag_a;
    logic [31:0]        w_mag_b;
    logic [64:0]        w_prod_full;
    logic [63:0]        w_round;
    logic signed [35:0] w_r_ext;
    logic signed [35:0] w_term;
    logic signed [31:0] w_acc;
    logic [31:0]        w_abs_p00;
    logic [31:0]        w_abs_p10;
    logic               w_div_start;
    logic [31:0]        w_div_num;
    akf_pkg::t_div_rsp  w_div_rsp;
    logic               w_k_neg;
    logic signed [31:0] w_k;

    // Write configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_noise <= akf_pkg::AngleNoiseRst;
            r_bias_noise  <= akf_pkg::BiasNoiseRst;
            r_meas_noise  <= akf_pkg::MeasNoiseRst;
            r_period      <= akf_pkg::PeriodRst;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                akf_pkg::CfgAngleNoise: r_angle_noise <= i_cfg_data;
                akf_pkg::CfgBiasNoise:  r_bias_noise  <= i_cfg_data;
                akf_pkg::CfgMeasNoise:  r_meas_noise  <= i_cfg_data;
                akf_pkg::CfgPeriod:     r_period      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Covariance derivative term, innovation variance
    assign w_d0_sum = $signed({3'b000, r_angle_noise}) - 34'(r_p01) - 34'(r_p10);
    assign w_e      = $signed({2'b00, r_meas_noise}) + 33'(r_p00);
    assign w_e_pos  = !w_e[32] && (w_e != '0);

    // Select multiplier operands and accumulate target for the current step
    always_comb begin
        w_opa  = '0;
        w_opb  = $signed({2'b00, r_period});
        w_sub  = 1'b0;
        w_base = r_angle;
        unique case (r_op)
            akf_pkg::OP_ANG_P: begin
                w_opa  = 33'(r_gyro) - 33'(r_bias);
                w_base = r_angle;
            end
            akf_pkg::OP_P00_P: begin
                w_opa  = 33'(r_d0);
                w_base = r_p00;
            end
            akf_pkg::OP_P01_P: begin
                w_opa  = 33'(r_p11);
                w_sub  = 1'b1;
                w_base = r_p01;
            end
            akf_pkg::OP_P10_P: begin
                w_opa  = 33'(r_p11);
                w_sub  = 1'b1;
                w_base = r_p10;
            end
            akf_pkg::OP_P11_P: begin
                w_opa  = $signed({2'b00, r_bias_noise});
                w_base = r_p11;
            end
            akf_pkg::OP_P00_C: begin
                w_opa  = 33'(r_k0);
                w_opb  = 33'(r_t0);
                w_sub  = 1'b1;
                w_base = r_p00;
            end
            akf_pkg::OP_P01_C: begin
                w_opa  = 33'(r_k0);
                w_opb  = 33'(r_t1);
                w_sub  = 1'b1;
                w_base = r_p01;
            end
            akf_pkg::OP_P10_C: begin
                w_opa  = 33'(r_k1);
                w_opb  = 33'(r_t0);
                w_sub  = 1'b1;
                w_base = r_p10;
            end
            akf_pkg::OP_P11_C: begin
                w_opa  = 33'(r_k1);
                w_opb  = 33'(r_t1);
                w_sub  = 1'b1;
                w_base = r_p11;
            end
            akf_pkg::OP_ANG_C: begin
                w_opa  = 33'(r_k0);
                w_opb  = 33'(r_err);
                w_base = r_angle;
            end
            akf_pkg::OP_BIAS_C: begin
                w_opa  = 33'(r_k1);
                w_opb  = 33'(r_err);
                w_base = r_bias;
            end
            default: ;
        endcase
    end

    // Shared sign-magnitude multiplier
    assign w_mag_a     = w_opa[32] ? $unsigned(-w_opa) : $unsigned(w_opa);
    assign w_mag_b     = w_opb[32] ? 32'($unsigned(-w_opb)) : 32'($unsigned(w_opb));
    assign w_prod_full = 65'(w_mag_a) * 65'(w_mag_b);

    // Round the registered product, apply the sign, add and clamp
    assign w_round = r_prod + 64'h0000_0000_2000_0000;
    assign w_r_ext = $signed({2'b00, w_round[63:30]});
    assign w_term  = r_neg ? -w_r_ext : w_r_ext;
    assign w_acc   = akf_pkg::sat32(36'(w_base) + w_term);

    // Divider operands and signed gain
    assign w_abs_p00 = r_p00[31] ? $unsigned(-r_p00) : $unsigned(r_p00);
    assign w_abs_p10 = r_p10[31] ? $unsigned(-r_p10) : $unsigned(r_p10);
    assign w_div_num = (r_state == akf_pkg::ST_CHECK) ? w_abs_p00 : w_abs_p10;
    assign w_k_neg   = r_ksel ? r_p10[31] : r_p00[31];
    assign w_k       = w_k_neg ? -$signed(w_div_rsp.quot) :
                       ((w_div_rsp.quot == 32'h8000_0000) ? 32'sh7FFF_FFFF :
                        $signed(w_div_rsp.quot));

    akf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_e[31:0]),
        .o_rsp   (w_div_rsp)
    );

    // Sequencer: next state and register updates
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_ksel      = r_ksel;
        n_out_valid = r_out_valid;
        n_angle     = r_angle;
        n_bias      = r_bias;
        n_p00       = r_p00;
        n_p01       = r_p01;
        n_p10       = r_p10;
        n_p11       = r_p11;
        n_accel     = r_accel;
        n_gyro      = r_gyro;
        n_d0        = r_d0;
        n_k0        = r_k0;
        n_k1        = r_k1;
        n_err       = r_err;
        n_t0        = r_t0;
        n_t1        = r_t1;
        n_prod      = r_prod;
        n_neg       = r_neg;
        n_angle_out = r_angle_out;
        n_rate_out  = r_rate_out;
        w_div_start = 1'b0;

        // Drop the result once the receiver takes it
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            akf_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_accel = i_accel_angle;
                    n_gyro  = i_gyro_rate;
                    n_d0    = akf_pkg::sat32(36'(w_d0_sum));
                    n_op    = akf_pkg::OP_ANG_P;
                    n_state = akf_pkg::ST_MUL;
                end
            end
            akf_pkg::ST_MUL: begin
                n_prod  = w_prod_full[63:0];
                n_neg   = w_opa[32] ^ w_opb[32] ^ w_sub;
                n_state = akf_pkg::ST_ACC;
            end
            akf_pkg::ST_ACC: begin
                // Write back to the step's target and advance
                n_state = akf_pkg::ST_MUL;
                unique case (r_op)
                    akf_pkg::OP_ANG_P: begin
                        n_angle = w_acc;
                        n_op    = akf_pkg::OP_P00_P;
                    end
                    akf_pkg::OP_P00_P: begin
                        n_p00 = w_acc;
                        n_op  = akf_pkg::OP_P01_P;
                    end
                    akf_pkg::OP_P01_P: begin
                        n_p01 = w_acc;
                        n_op  = akf_pkg::OP_P10_P;
                    end
                    akf_pkg::OP_P10_P: begin
                        n_p10 = w_acc;
                        n_op  = akf_pkg::OP_P11_P;
                    end
                    akf_pkg::OP_P11_P: begin
                        n_p11   = w_acc;
                        n_state = akf_pkg::ST_CHECK;
                    end
                    akf_pkg::OP_P00_C: begin
                        n_p00 = w_acc;
                        n_op  = akf_pkg::OP_P01_C;
                    end
                    akf_pkg::OP_P01_C: begin
                        n_p01 = w_acc;
                        n_op  = akf_pkg::OP_P10_C;
                    end
                    akf_pkg::OP_P10_C: begin
                        n_p10 = w_acc;
                        n_op  = akf_pkg::OP_P11_C;
                    end
                    akf_pkg::OP_P11_C: begin
                        n_p11 = w_acc;
                        n_op  = akf_pkg::OP_ANG_C;
                    end
                    akf_pkg::OP_ANG_C: begin
                        n_angle = w_acc;
                        n_op    = akf_pkg::OP_BIAS_C;
                    end
                    akf_pkg::OP_BIAS_C: begin
                        n_bias  = w_acc;
                        n_state = akf_pkg::ST_RESULT;
                    end
                    default: begin
                        n_state = akf_pkg::ST_RESULT;
                    end
                endcase
            end
            akf_pkg::ST_CHECK: begin
                // Skip the correction when the innovation variance is not positive
                if (w_e_pos) begin
                    n_err       = akf_pkg::sat32(36'(r_accel) - 36'(r_angle));
                    n_t0        = r_p00;
                    n_t1        = r_p01;
                    n_ksel      = 1'b0;
                    w_div_start = 1'b1;
                    n_state     = akf_pkg::ST_DIV;
                end else begin
                    n_state = akf_pkg::ST_RESULT;
                end
            end
            akf_pkg::ST_DIV: begin
                if (w_div_rsp.done) begin
                    if (!r_ksel) begin
                        n_k0        = w_k;
                        n_ksel      = 1'b1;
                        w_div_start = 1'b1;
                    end else begin
                        n_k1    = w_k;
                        n_op    = akf_pkg::OP_P00_C;
                        n_state = akf_pkg::ST_MUL;
                    end
                end
            end
            akf_pkg::ST_RESULT: begin
                // Hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_angle_out = r_angle;
                    n_rate_out  = akf_pkg::sat32(36'(r_gyro) - 36'(r_bias));
                    n_state     = akf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = akf_pkg::ST_IDLE;
            end
        endcase
    end

    // Control and filter state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= akf_pkg::ST_IDLE;
            r_op        <= akf_pkg::OP_ANG_P;
            r_ksel      <= 1'b0;
            r_out_valid <= 1'b0;
            r_angle     <= '0;
            r_bias      <= '0;
            r_p00       <= akf_pkg::OneQ30;
            r_p01       <= '0;
            r_p10       <= '0;
            r_p11       <= akf_pkg::OneQ30;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_ksel      <= n_ksel;
            r_out_valid <= n_out_valid;
            r_angle     <= n_angle;
            r_bias      <= n_bias;
            r_p00       <= n_p00;
            r_p01       <= n_p01;
            r_p10       <= n_p10;
            r_p11       <= n_p11;
        end
    end

    // Working and output data registers
    always_ff @(posedge i_clk) begin
        r_accel     <= n_accel;
        r_gyro      <= n_gyro;
        r_d0        <= n_d0;
        r_k0        <= n_k0;
        r_k1        <= n_k1;
        r_err       <= n_err;
        r_t0        <= n_t0;
        r_t1        <= n_t1;
        r_prod      <= n_prod;
        r_neg       <= n_neg;
        r_angle_out <= n_angle_out;
        r_rate_out  <= n_rate_out;
    end

    assign o_in_ready       = (r_state == akf_pkg::ST_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_angle_estimate = r_angle_out;
    assign o_rate_estimate  = r_rate_out;

endmodule

`default_nettype wire

[tb/sv/angle_kalman_filter_core_test.sv]
// ============================================================================
// angle_kalman_filter_core_test: self-checking bench for the angle Kalman filter
// Streams accel/gyro words through the core under several register settings.
// A fixed-point copy of the filter predicts every estimate word, and each
// output word is compared field by field with the oldest prediction.
// ============================================================================
`default_nettype none

typedef struct packed {
    logic signed [31:0] angle;
    logic signed [31:0] rate;
} t_estimate;

// Filter state, register copy and the queue of predicted estimate words
class estimate_board;
    logic [30:0]        angle_noise;
    logic [30:0]        bias_noise;
    logic [30:0]        meas_noise;
    logic [30:0]        period;
    logic signed [31:0] angle_est;
    logic signed [31:0] bias_est;
    logic signed [31:0] cov [4];
    t_estimate          pending_estimates [$];
    int                 errors;
    int                 samples;
    int                 skipped;
    int                 checked;

    function new();
        angle_noise = akf_pkg::AngleNoiseRst;
        bias_noise  = akf_pkg::BiasNoiseRst;
        meas_noise  = akf_pkg::MeasNoiseRst;
        period      = akf_pkg::PeriodRst;
        angle_est   = '0;
        bias_est    = '0;
        cov[0]      = akf_pkg::OneQ30;
        cov[1]      = '0;
        cov[2]      = '0;
        cov[3]      = akf_pkg::OneQ30;
        errors      = 0;
        samples     = 0;
        skipped     = 0;
        checked     = 0;
    endfunction

    function longint clamp32(longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function longint unsigned magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Product rescaled by 2^30, rounded half away from zero
    function longint qmul(longint a, longint b);
        longint unsigned p;
        p = (magnitude(a) * magnitude(b) + 64'd536870912) >> 30;
        return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    // Quotient in Q2.30, rounded half away from zero, clamped
    function longint qdiv(longint n, longint d);
        longint unsigned num;
        longint unsigned den;
        longint unsigned q;
        num = magnitude(n) << 30;
        den = d;
        q = (num + den / 2) / den;
        if (q > 64'h8000_0000) begin
            q = 64'h8000_0000;
        end
        return clamp32((n < 0) ? -longint'(q) : longint'(q));
    endfunction

    function void write_reg(logic [akf_pkg::CfgIdxW-1:0] index,
                            logic [akf_pkg::CfgDataW-1:0] data);
        case (index)
            akf_pkg::CfgAngleNoise: angle_noise = data;
            akf_pkg::CfgBiasNoise:  bias_noise = data;
            akf_pkg::CfgMeasNoise:  meas_noise = data;
            akf_pkg::CfgPeriod:     period = data;
            default: ;
        endcase
    endfunction

    // Run one predict/correct step and queue the estimate word it gives
    function void note_sample(logic signed [31:0] accel_in, logic signed [31:0] gyro_in);
        longint    accel, gyro, dt, an, bn, mn;
        longint    ang, bs, p00, p01, p10, p11;
        longint    d0, e, err, k0, k1, t0, t1;
        t_estimate est;
        accel = longint'(accel_in);
        gyro  = longint'(gyro_in);
        dt    = longint'(period);
        an    = longint'(angle_noise);
        bn    = longint'(bias_noise);
        mn    = longint'(meas_noise);
        ang   = longint'(angle_est);
        bs    = longint'(bias_est);
        p00   = longint'(cov[0]);
        p01   = longint'(cov[1]);
        p10   = longint'(cov[2]);
        p11   = longint'(cov[3]);

        // Predict angle and grow the covariance
        ang = clamp32(ang + qmul(gyro - bs, dt));
        d0  = clamp32(an - p01 - p10);
        p00 = clamp32(p00 + qmul(d0, dt));
        p01 = clamp32(p01 + qmul(-p11, dt));
        p10 = clamp32(p10 + qmul(-p11, dt));
        p11 = clamp32(p11 + qmul(bn, dt));

        // Correct only while the innovation variance is positive
        e = mn + p00;
        if (e > 0) begin
            err = clamp32(accel - ang);
            k0  = qdiv(p00, e);
            k1  = qdiv(p10, e);
            t0  = p00;
            t1  = p01;
            p00 = clamp32(p00 - qmul(k0, t0));
            p01 = clamp32(p01 - qmul(k0, t1));
            p10 = clamp32(p10 - qmul(k1, t0));
            p11 = clamp32(p11 - qmul(k1, t1));
            ang = clamp32(ang + qmul(k0, err));
            bs  = clamp32(bs + qmul(k1, err));
        end else begin
            skipped++;
        end

        angle_est = ang[31:0];
        bias_est  = bs[31:0];
        cov[0]    = p00[31:0];
        cov[1]    = p01[31:0];
        cov[2]    = p10[31:0];
        cov[3]    = p11[31:0];
        est.angle = ang[31:0];
        est.rate  = 32'(clamp32(gyro - bs));
        pending_estimates.push_back(est);
        samples++;
    endfunction

    function void check_estimate(logic signed [31:0] angle_out,
                                 logic signed [31:0] rate_out);
        t_estimate exp_est;
        if (pending_estimates.size() == 0) begin
            $error("estimate word with none expected: angle %0d rate %0d",
                   angle_out, rate_out);
            errors++;
        end else begin
            exp_est = pending_estimates.pop_front();
            checked++;
            if (angle_out !== exp_est.angle) begin
                $error("angle_estimate mismatch: expected %0d, actual %0d",
                       exp_est.angle, angle_out);
                errors++;
            end
            if (rate_out !== exp_est.rate) begin
                $error("rate_estimate mismatch: expected %0d, actual %0d",
                       exp_est.rate, rate_out);
                errors++;
            end
        end
    endfunction

    function int pending();
        return pending_estimates.size();
    endfunction
endclass

module angle_kalman_filter_core_test;

    localparam int WatchdogLimit = 2000;
    localparam int IdleGuard     = 8;
    localparam int SettleCycles  = 100;
    localparam int Phases        = 10;
    localparam int WordsPerPhase = 183;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n;
    logic                               i_cfg_valid;
    logic                               o_cfg_ready;
    logic [akf_pkg::CfgIdxW-1:0]        i_cfg_index;
    logic [akf_pkg::CfgDataW-1:0]       i_cfg_data;
    logic                               i_in_valid;
    logic                               o_in_ready;
    logic signed [31:0]                 i_accel_angle;
    logic signed [31:0]                 i_gyro_rate;
    logic                               o_out_valid;
    logic                               i_out_ready;
    logic signed [31:0]                 o_angle_estimate;
    logic signed [31:0]                 o_rate_estimate;

    estimate_board board;
    int            idle_cycles = 0;
    int            stall_left;
    int            settings_applied;
    bit            in_gaps_on;
    bit            out_stalls_on;
    int            track_angle;
    int            track_rate;
    int            gyro_offset;

    angle_kalman_filter_core uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_accel_angle    (i_accel_angle),
        .i_gyro_rate      (i_gyro_rate),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_angle_estimate (o_angle_estimate),
        .o_rate_estimate  (o_rate_estimate)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 20);
        end
        return $urandom_range(40, 150);
    endfunction

    function automatic logic signed [31:0] extreme_word();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return 32'sd0;
            3: return 32'sd1;
            4: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [akf_pkg::CfgDataW-1:0] pick_reg_value();
        case ($urandom_range(0, 3))
            0: return akf_pkg::CfgDataW'($urandom);
            1: return akf_pkg::CfgDataW'($urandom_range(0, 16777216));
            2: return akf_pkg::CfgDataW'($urandom_range(0, 1048576));
            default: return ($urandom_range(0, 1) == 1) ? 31'h7FFF_FFFF : 31'd1;
        endcase
    endfunction

    // Receiver: stall at random while enabled, otherwise take every word
    initial begin
        i_out_ready = 1'b0;
        stall_left  = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
                if (out_stalls_on && $urandom_range(0, 5) == 0) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    // Observe handshakes, feed the board and guard against a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                board.write_reg(i_cfg_index, i_cfg_data);
            end
            if (i_in_valid && o_in_ready) begin
                board.note_sample(i_accel_angle, i_gyro_rate);
            end
            if (o_out_valid && i_out_ready) begin
                board.check_estimate(o_angle_estimate, o_rate_estimate);
            end
            if ((i_cfg_valid && o_cfg_ready) || (i_in_valid && o_in_ready) ||
                (o_out_valid && i_out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WatchdogLimit) begin
                $display("angle_kalman_filter_core_test failed");
                $finish;
            end
        end
    end

    // Offer one sample word after an optional gap; return at the next falling edge
    task automatic send_sample(input logic signed [31:0] accel,
                               input logic signed [31:0] gyro, input int gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_accel_angle <= accel;
        i_gyro_rate   <= gyro;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Hold off the sender until every predicted estimate has come back
    task automatic drain_estimates();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (board.pending() != 0);
    endtask

    // Leaves the write valid high; the caller lowers it after the last word
    task automatic write_cfg(input logic [akf_pkg::CfgIdxW-1:0] index,
                             input logic [akf_pkg::CfgDataW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic apply_settings(input logic [akf_pkg::CfgDataW-1:0] an,
                                  input logic [akf_pkg::CfgDataW-1:0] bn,
                                  input logic [akf_pkg::CfgDataW-1:0] mn,
                                  input logic [akf_pkg::CfgDataW-1:0] dt);
        drain_estimates();
        repeat (IdleGuard) @(negedge i_clk);
        write_cfg(akf_pkg::CfgIdxW'($urandom_range(4, 255)),
                  akf_pkg::CfgDataW'($urandom));
        write_cfg(akf_pkg::CfgAngleNoise, an);
        write_cfg(akf_pkg::CfgBiasNoise, bn);
        write_cfg(akf_pkg::CfgMeasNoise, mn);
        write_cfg(akf_pkg::CfgPeriod, dt);
        i_cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    // Mix of a plausible motion track, raw random words and full-scale words
    task automatic send_random_sample();
        int                 r;
        int                 gap;
        logic signed [31:0] accel;
        logic signed [31:0] gyro;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            track_rate = track_rate + int'($urandom_range(0, 2097152)) - 1048576;
            if (track_rate > 524288000 || track_rate < -524288000) begin
                track_rate = -track_rate / 2;
            end
            track_angle = track_angle + track_rate / 128;
            if (track_angle > 188743680 || track_angle < -188743680) begin
                track_rate = -track_rate;
            end
            accel = track_angle + int'($urandom_range(0, 1048576)) - 524288;
            gyro  = track_rate + gyro_offset;
        end else if (r < 85) begin
            accel = $urandom;
            gyro  = $urandom;
        end else begin
            accel = extreme_word();
            gyro  = extreme_word();
        end
        gap = (in_gaps_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
        if ($urandom_range(0, 149) == 0) begin
            drain_estimates();
        end
        send_sample(accel, gyro, gap);
    endtask

    initial begin
        board            = new();
        i_rst_n          = 1'b0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = '0;
        i_cfg_data       = '0;
        i_in_valid       = 1'b0;
        i_accel_angle    = '0;
        i_gyro_rate      = '0;
        settings_applied = 0;
        in_gaps_on       = 1'b0;
        out_stalls_on    = 1'b0;
        track_angle      = 0;
        track_rate       = 0;
        gyro_offset      = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed corners at reset settings: field extremes, saturated
        // innovation and prediction, then a few plausible words
        send_sample(32'sd0, 32'sd0, 0);
        send_sample(32'sh7FFF_FFFF, 32'sd0, 0);
        send_sample(32'sh8000_0000, 32'sd0, 0);
        send_sample(32'sd0, 32'sh7FFF_FFFF, 0);
        send_sample(32'sd0, 32'sh8000_0000, 0);
        send_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0);
        send_sample(32'sh8000_0000, 32'sh8000_0000, 0);
        send_sample(32'sh7FFF_FFFF, 32'sh8000_0000, 0);
        send_sample(32'sh8000_0000, 32'sh7FFF_FFFF, 0);
        send_sample(32'sd1, -32'sd1, 0);
        send_sample(-32'sd1, 32'sd1, 0);
        send_sample(32'sd0, 32'sd0, 0);
        send_sample(32'sd10485760, 32'sd1048576, 0);
        send_sample(-32'sd10485760, -32'sd1048576, 0);
        send_sample(32'sd104857600, 32'sd0, 0);
        send_sample(32'sd0, 32'sd0, 0);

        // Random phases, each under its own settings and idle pattern
        for (int ph = 0; ph < Phases; ph++) begin
            case (ph)
                0: apply_settings(akf_pkg::AngleNoiseRst, akf_pkg::BiasNoiseRst,
                                  akf_pkg::MeasNoiseRst, akf_pkg::PeriodRst);
                1: apply_settings(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                                  31'h7FFF_FFFF);
                2: apply_settings(31'd0, 31'd0, 31'd1, 31'd1);
                // Zero measurement noise collapses P00, so the correction
                // stops once the innovation variance reaches zero
                3: apply_settings(31'd0, 31'd0, 31'd0, 31'd1);
                4: apply_settings(pick_reg_value(), pick_reg_value(),
                                  pick_reg_value() | 31'd1, 31'd1073741824);
                default: begin
                    apply_settings(pick_reg_value(), pick_reg_value(),
                                   pick_reg_value() | 31'd1,
                                   ($urandom_range(0, 3) == 0) ?
                                       (pick_reg_value() | 31'd1) :
                                       akf_pkg::CfgDataW'($urandom_range(1, 33554432)));
                end
            endcase
            in_gaps_on    = (ph % 2) == 1;
            out_stalls_on = ((ph / 2) % 2) == 1;
            gyro_offset   = int'($urandom_range(0, 20971520)) - 10485760;
            repeat (WordsPerPhase) send_random_sample();
        end

        drain_estimates();
        repeat (SettleCycles) @(negedge i_clk);

        $display("Covered %0d sample words under %0d register settings: corners, tracks, raw.",
                 board.samples, settings_applied + 1);
        $display("Correction skipped on %0d samples; %0d estimate words compared.",
                 board.skipped, board.checked);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("angle_kalman_filter_core_test passed");
        end else begin
            $display("angle_kalman_filter_core_test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
src/akf_pkg.sv
src/akf_div.sv
src/angle_kalman_filter_core.sv
tb/sv/angle_kalman_filter_core_test.sv
